FILE: rtl/core/nkps_pkg.sv
// nkps_pkg: shared types and constants for nearest_k_point_selection
// depends on nothing
`default_nettype none
package nkps_pkg;
    localparam int COORD_W = 16;
    localparam int NCOORD  = 6;
    localparam int SQ_W    = 35;
    localparam int DIST_W  = 18;
    localparam int KEEP_W  = 7;
    localparam int KEEP_REG = 6;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef coord_t [NCOORD-1:0] point_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIST,
        ST_SUM,
        ST_INSERT,
        ST_EMIT
    } state_t;

    // per-lane compare verdicts handed to the merge stage
    typedef struct packed {
        logic farther;
    } lane_res_t;
endpackage
`default_nettype wire

FILE: rtl/core/nkps_lane.sv
// nkps_lane: one kept-entry slot; holds a point and its squared distance
// and compares it against the incoming candidate; depends on nkps_pkg
`default_nettype none
module nkps_lane
(
    input  wire logic                        clk,
    input  wire logic [nkps_pkg::SQ_W-1:0]   cand_sq,
    input  wire nkps_pkg::point_t            cand_pt,
    input  wire logic [nkps_pkg::SQ_W-1:0]   prev_sq,
    input  wire nkps_pkg::point_t            prev_pt,
    input  wire logic                        load_cand,
    input  wire logic                        load_prev,
    output nkps_pkg::lane_res_t              res,
    output logic [nkps_pkg::SQ_W-1:0]        sq,
    output nkps_pkg::point_t                 pt
);
    logic [nkps_pkg::SQ_W-1:0] sq_reg;
    nkps_pkg::point_t          pt_reg;

    always_ff @(posedge clk)
    begin
        if (load_cand)
        begin
            sq_reg <= cand_sq;
            pt_reg <= cand_pt;
        end
        else if (load_prev)
        begin
            sq_reg <= prev_sq;
            pt_reg <= prev_pt;
        end
    end

    assign res.farther = (cand_sq < sq_reg);
    assign sq = sq_reg;
    assign pt = pt_reg;
endmodule
`default_nettype wire

FILE: rtl/core/nkps_sqrt.sv
// nkps_sqrt: iterative floor square root, one result bit a cycle
// depends on nkps_pkg
`default_nettype none
module nkps_sqrt
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          go,
    input  wire logic [nkps_pkg::SQ_W-1:0]     value,
    output logic                               done,
    output logic [nkps_pkg::DIST_W-1:0]        root
);
    localparam int RW = 38;
    logic [RW-1:0] rem_reg, rem_next;
    logic [RW-1:0] res_reg, res_next;
    logic [RW-1:0] bit_reg, bit_next;
    logic          busy_reg, busy_next;

    always_comb
    begin
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        if (go)
        begin
            rem_next  = {3'b0, value};
            res_next  = '0;
            bit_next  = RW'(1) << 36;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= res_reg + bit_reg)
            begin
                rem_next = rem_reg - (res_reg + bit_reg);
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = busy_reg && bit_reg[0];
    assign root = res_next[nkps_pkg::DIST_W-1:0];
endmodule
`default_nettype wire

FILE: rtl/core/nearest_k_point_selection.sv
// nearest_k_point_selection: top level, distance unit, lane array, merge
// depends on nkps_pkg, nkps_lane, nkps_sqrt
`default_nettype none
// usage
//   write ref_coord0..5 (index 0..5) and keep_count (index 6) through
//   cfg_we/cfg_index/cfg_data while the block is idle
//   pulse start with a point when busy is low; batch_end marks the last one
//   after the transfer busy stays high through ST_DIST for the six squared
//   differences, ST_SUM for their sum and ST_INSERT, where every lane
//   compares in parallel and the priority merge shifts the store; a new
//   point is taken only once busy is low again
//   on batch_end the kept entries are emitted nearest first, one at a time,
//   each waiting on the shared iterative square root, one bit a cycle;
//   each result is valid for exactly one cycle on out_valid and
//   last_result marks the final one; the store is then empty
//   reset clears the fill count, keep_count returns to 64 and the
//   reference to zero; the receiver cannot stall
module nearest_k_point_selection #(
    parameter int MAX_KEPT   = 64,
    parameter int DIMENSIONS = 6
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        start,
    output logic             busy,
    input  wire logic signed [15:0] pt_coord0,
    input  wire logic signed [15:0] pt_coord1,
    input  wire logic signed [15:0] pt_coord2,
    input  wire logic signed [15:0] pt_coord3,
    input  wire logic signed [15:0] pt_coord4,
    input  wire logic signed [15:0] pt_coord5,
    input  wire logic        batch_end,
    output logic             out_valid,
    output logic signed [15:0] out_coord0,
    output logic signed [15:0] out_coord1,
    output logic signed [15:0] out_coord2,
    output logic signed [15:0] out_coord3,
    output logic signed [15:0] out_coord4,
    output logic signed [15:0] out_coord5,
    output logic [17:0]      distance,
    output logic             last_result
);
    localparam int CW = $clog2(MAX_KEPT + 1);
    localparam int LW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

    nkps_pkg::point_t ref_reg;
    logic [nkps_pkg::KEEP_W-1:0] keep_reg;
    nkps_pkg::state_t state_reg, state_next;
    nkps_pkg::point_t cand_reg;
    logic end_reg;
    logic [33:0] sqd_reg [nkps_pkg::NCOORD];
    logic [nkps_pkg::SQ_W-1:0] cand_sq_reg, sum;
    logic [CW-1:0] count_reg, count_next, limit;
    logic [CW-1:0] emit_reg, emit_next;
    logic load_d, load_ins;
    logic sqrt_go, sqrt_done;
    logic [nkps_pkg::DIST_W-1:0] root;
    logic waiting_reg, waiting_next;

    nkps_pkg::lane_res_t res [MAX_KEPT];
    logic [nkps_pkg::SQ_W-1:0] lsq [MAX_KEPT];
    nkps_pkg::point_t lpt [MAX_KEPT];
    logic [MAX_KEPT-1:0] ld_c, ld_p;

    always_comb
    begin
        if (keep_reg == '0)
            limit = CW'(1);
        else if (32'(keep_reg) > MAX_KEPT)
            limit = CW'(MAX_KEPT);
        else
            limit = CW'(keep_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg  <= '0;
            keep_reg <= nkps_pkg::KEEP_W'(64);
        end
        else if (cfg_we)
        begin
            if (32'(cfg_index) < nkps_pkg::KEEP_REG)
                ref_reg[cfg_index] <= cfg_data;
            else if (32'(cfg_index) == nkps_pkg::KEEP_REG)
                keep_reg <= cfg_data[nkps_pkg::KEEP_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cand_reg <= {pt_coord5, pt_coord4, pt_coord3, pt_coord2,
                         pt_coord1, pt_coord0};
            end_reg  <= batch_end;
        end
        if (load_d)
        begin
            for (int d = 0; d < nkps_pkg::NCOORD; d++)
            begin
                logic signed [16:0] df;
                df = 17'(cand_reg[d]) - 17'(ref_reg[d]);
                sqd_reg[d] <= (d < DIMENSIONS) ? 34'(df * df) : '0;
            end
        end
        cand_sq_reg <= sum;
    end

    always_comb
    begin
        sum = '0;
        for (int d = 0; d < nkps_pkg::NCOORD; d++)
            sum = sum + nkps_pkg::SQ_W'(sqd_reg[d]);
    end

    // lanes and priority merge: insert before first strictly farther lane
    logic [CW-1:0] cnt_cut;
    assign cnt_cut = (count_reg > limit) ? limit : count_reg;

    genvar g;
    generate
        for (g = 0; g < MAX_KEPT; g++)
        begin : g_lane
            logic here_far, prev_far;
            assign here_far = res[g].farther || (CW'(g) >= cnt_cut);
            if (g == 0)
            begin : g_first
                assign prev_far = 1'b0;
                nkps_lane u_lane (
                    .clk(clk), .cand_sq(cand_sq_reg), .cand_pt(cand_reg),
                    .prev_sq(lsq[0]), .prev_pt(lpt[0]),
                    .load_cand(ld_c[g]), .load_prev(ld_p[g]),
                    .res(res[g]), .sq(lsq[g]), .pt(lpt[g]));
            end
            else
            begin : g_rest
                assign prev_far = res[g-1].farther || (CW'(g-1) >= cnt_cut);
                nkps_lane u_lane (
                    .clk(clk), .cand_sq(cand_sq_reg), .cand_pt(cand_reg),
                    .prev_sq(lsq[g-1]), .prev_pt(lpt[g-1]),
                    .load_cand(ld_c[g]), .load_prev(ld_p[g]),
                    .res(res[g]), .sq(lsq[g]), .pt(lpt[g]));
            end
            assign ld_c[g] = load_ins && here_far && !prev_far && (CW'(g) < limit);
            assign ld_p[g] = load_ins && prev_far && (CW'(g) < limit)
                             && (CW'(g) <= cnt_cut);
        end
    endgenerate

    logic ins_ok;
    always_comb
    begin
        ins_ok = 1'b0;
        for (int j = 0; j < MAX_KEPT; j++)
            ins_ok = ins_ok | ld_c[j];
    end

    assign sqrt_go = (state_reg == nkps_pkg::ST_EMIT) && !waiting_reg
                     && (emit_reg < count_reg);

    nkps_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .go(sqrt_go),
        .value(lsq[emit_reg[LW-1:0]]), .done(sqrt_done), .root(root));

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        emit_next    = emit_reg;
        waiting_next = waiting_reg;
        load_d       = 1'b0;
        load_ins     = 1'b0;
        case (state_reg)
            nkps_pkg::ST_IDLE:
                if (start)
                    state_next = nkps_pkg::ST_DIST;
            nkps_pkg::ST_DIST:
            begin
                load_d     = 1'b1;
                state_next = nkps_pkg::ST_SUM;
            end
            nkps_pkg::ST_SUM:
                state_next = nkps_pkg::ST_INSERT;
            nkps_pkg::ST_INSERT:
            begin
                load_ins   = 1'b1;
                count_next = cnt_cut;
                if (ins_ok && cnt_cut < limit)
                    count_next = cnt_cut + CW'(1);
                emit_next  = '0;
                state_next = end_reg ? nkps_pkg::ST_EMIT : nkps_pkg::ST_IDLE;
            end
            nkps_pkg::ST_EMIT:
            begin
                if (sqrt_go)
                    waiting_next = 1'b1;
                else if (sqrt_done)
                begin
                    waiting_next = 1'b0;
                    emit_next    = emit_reg + CW'(1);
                end
                else if (!waiting_reg)
                begin
                    count_next = '0;
                    state_next = nkps_pkg::ST_IDLE;
                end
            end
            default: state_next = nkps_pkg::ST_IDLE;
        endcase
    end

    // ST_DIST needs cand_reg; the sum is ready in ST_SUM from the registered squares
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= nkps_pkg::ST_IDLE;
            count_reg   <= '0;
            emit_reg    <= '0;
            waiting_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            emit_reg    <= emit_next;
            waiting_reg <= waiting_next;
        end
    end

    assign busy        = (state_reg != nkps_pkg::ST_IDLE);
    assign out_valid   = (state_reg == nkps_pkg::ST_EMIT) && sqrt_done;
    assign out_coord0  = lpt[emit_reg[LW-1:0]][0];
    assign out_coord1  = lpt[emit_reg[LW-1:0]][1];
    assign out_coord2  = lpt[emit_reg[LW-1:0]][2];
    assign out_coord3  = lpt[emit_reg[LW-1:0]][3];
    assign out_coord4  = lpt[emit_reg[LW-1:0]][4];
    assign out_coord5  = lpt[emit_reg[LW-1:0]][5];
    assign distance    = root;
    assign last_result = (emit_reg + CW'(1) == count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= MAX_KEPT) else $error("fill count above store depth");
    a_out_only_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> state_reg == nkps_pkg::ST_EMIT) else $error("result outside emit");
    a_empty_after: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nkps_pkg::ST_EMIT && state_next == nkps_pkg::ST_IDLE)
        |=> count_reg == '0) else $error("store not emptied");
endmodule
`default_nettype wire
